// ===== sv/order_book_price_level_map_unit_defines.svh =====
// Assertion macros shared by the order book checker.
// Included by the checker file; depends on a clk and rst in scope.
`ifndef ORDER_BOOK_PRICE_LEVEL_MAP_UNIT_DEFINES_SVH
`define ORDER_BOOK_PRICE_LEVEL_MAP_UNIT_DEFINES_SVH

// Checked on every edge once reset has been released.
`define OBPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, including those in reset.
`define OBPL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/obpl_pkg.sv =====
// Shared types and codes for the order book price level map.
// No dependencies; used by the top level, the checker and the testbench.
package obpl_pkg;

  localparam int QTY_W = 48;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_MISALIGN  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;

  localparam logic [1:0] CFG_MIN_PRICE   = 2'd0;
  localparam logic [1:0] CFG_TICK_SIZE   = 2'd1;
  localparam logic [1:0] CFG_LEVEL_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] price;
    logic [11:0] ord_id;
    logic [31:0] order_qty;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [QTY_W-1:0] level_qty;
    logic             bid_valid;
    logic [31:0]      bid_price;
    logic [QTY_W-1:0] bid_qty;
    logic             ask_valid;
    logic [31:0]      ask_price;
    logic [QTY_W-1:0] ask_qty;
  } out_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RANGE, S_CMP, S_DIV, S_LVL, S_LINK, S_RM, S_RMP, S_RMN,
    S_BID0, S_BRD, S_BCK, S_ASK0, S_ARD, S_ACK, S_REPORT, S_RB, S_RA, S_OUT
  } state_t;

endpackage

// ===== sv/obpl_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module obpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/obpl_div.sv =====
// Restoring divider, one quotient bit per cycle, 32 by 16 bits.
// Depends on nothing; used by the top level for the price to level mapping.
module obpl_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [15:0] rem
);

  logic        busy;
  logic [4:0]  cnt;
  logic [15:0] dsr;
  logic [16:0] trial;
  logic        ge;

  assign trial = {rem, quot[31]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        rem  <= ge ? 16'(trial - {1'b0, dsr}) : trial[15:0];
        quot <= {quot[30:0], ge};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/order_book_price_level_map_unit.sv =====
// Order book price level map: top level with its sequencer and memories.
// Depends on obpl_pkg, obpl_ram and obpl_div.
//
// Items come in on in_valid/in_stall/in_data and one result per item leaves on
// out_valid/out_stall/out_data; a transfer happens when valid is high and stall
// is low. The block takes one item at a time and holds in_stall high meanwhile.
// A query or a remove of an unknown id is reported at once; other prices are
// range checked, and a price in range goes through a serial divider that gives
// its level and alignment. A misaligned price or a refused item is then
// reported; an insert writes its level and order, linking behind the old tail
// of an active level, and a remove unlinks its order. A remove that empties a
// best level scans the level activity memory, reading a level in S_BRD or S_ARD
// and checking it in S_BCK or S_ACK. The next item can be taken in the cycle
// after the load. The shared multiplier forms the range limit and the prices.
// A stalled result holds in the output register; the next item is taken while it
// waits, and the block then holds its next result until the register is free.
// After reset a clearing pass clears the level activity and order live
// memories; no item is taken during it.
// Configuration writes through cfg_we/cfg_index/cfg_data at any time.
module order_book_price_level_map_unit
  import obpl_pkg::*;
#(
  parameter int LEVELS = 1024,
  parameter int ORDERS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int LW    = $clog2(LEVELS);
  localparam int IW    = $clog2(LEVELS + 1);
  localparam int OW    = $clog2(ORDERS);
  localparam int OPW   = $clog2(ORDERS + 1);
  localparam int PW    = IW + 16;
  localparam int CLR_N = (LEVELS > ORDERS) ? LEVELS : ORDERS;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [OPW-1:0] NONE_O = OPW'(ORDERS);
  localparam logic [IW-1:0]  NONE_L = IW'(LEVELS);

  typedef struct packed {
    logic [OPW-1:0]   head;
    logic [OPW-1:0]   tail;
    logic [QTY_W-1:0] total;
  } lvl_t;

  typedef struct packed {
    logic [OPW-1:0] prev;
    logic [OPW-1:0] next;
    logic [31:0]    amount;
    logic [LW-1:0]  level;
  } ord_t;

  state_t state, state_next;

  logic [31:0] base_price;
  logic [15:0] price_step;
  logic [10:0] level_count;

  logic [CW-1:0] clr;
  in_t           req;
  logic          live_q;
  ord_t          ordq;
  lvl_t          lvlq;
  logic [PW-1:0] lim;
  logic [PW-1:0] prod;
  logic          below;
  logic [31:0]   diff;
  logic [LW-1:0] idx;
  logic [LW-1:0] scan;
  logic [2:0]    status_r;
  logic [QTY_W-1:0] lq;
  logic [IW-1:0] bb, ba;
  logic [QTY_W-1:0] bid_tot, ask_tot;
  logic [31:0]   bid_prc, ask_prc;

  logic          act_we, act_wd, act_rd, live_we, live_wd, live_rd;
  logic [LW-1:0] act_wa, act_ra, lvl_wa, lvl_ra;
  logic [OW-1:0] live_wa, live_ra, ord_wa, ord_ra;
  logic          lvl_we, ord_we;
  lvl_t          lvl_wd, lvl_rd;
  ord_t          ord_wd, ord_rd;

  logic          div_start, div_done;
  logic [31:0]   div_quot;
  logic [15:0]   div_rem;

  logic [15:0]   tick_eff;
  logic [IW-1:0] cnt;
  logic [IW-1:0] mul_a;
  logic [PW-1:0] mul_p;
  logic          oid_big;
  logic [OW-1:0] oid;
  logic [QTY_W-1:0] ins_tot, rm_tot;
  logic [OPW-1:0] rm_head, rm_tail;
  logic          load;

  assign tick_eff = (price_step == 16'd0) ? 16'd1 : price_step;
  assign cnt      = (32'(level_count) > 32'(LEVELS)) ? NONE_L : IW'(level_count);
  assign mul_p    = PW'(mul_a) * PW'(tick_eff);
  assign oid_big  = 32'(req.ord_id) >= 32'(ORDERS);
  assign oid      = OW'(req.ord_id);
  assign ins_tot  = (act_rd ? lvl_rd.total : '0) + QTY_W'(req.order_qty);
  assign rm_tot   = lvlq.total - QTY_W'(ordq.amount);
  assign rm_head  = (ordq.prev == NONE_O) ? ordq.next : lvlq.head;
  assign rm_tail  = (ordq.next == NONE_O) ? ordq.prev : lvlq.tail;
  assign in_stall = (state != S_IDLE);
  assign load     = (state == S_OUT) && (!out_valid || !out_stall);

  obpl_ram #(.WIDTH(1), .DEPTH(LEVELS)) u_act (
    .clk(clk), .we(act_we), .waddr(act_wa), .wdata(act_wd), .raddr(act_ra), .rdata(act_rd)
  );
  obpl_ram #(.WIDTH($bits(lvl_t)), .DEPTH(LEVELS)) u_lvl (
    .clk(clk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd), .raddr(lvl_ra), .rdata(lvl_rd)
  );
  obpl_ram #(.WIDTH(1), .DEPTH(ORDERS)) u_live (
    .clk(clk), .we(live_we), .waddr(live_wa), .wdata(live_wd), .raddr(live_ra),
    .rdata(live_rd)
  );
  obpl_ram #(.WIDTH($bits(ord_t)), .DEPTH(ORDERS)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd)
  );

  obpl_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(diff), .divisor(tick_eff),
    .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_price  <= '0;
      price_step  <= 16'd1;
      level_count <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PRICE:   base_price  <= cfg_data;
        CFG_TICK_SIZE:   price_step  <= cfg_data[15:0];
        CFG_LEVEL_COUNT: level_count <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    act_we = 1'b0; act_wa = idx; act_wd = 1'b0; act_ra = idx;
    lvl_we = 1'b0; lvl_wa = idx; lvl_wd = '0; lvl_ra = idx;
    live_we = 1'b0; live_wa = oid; live_wd = 1'b0; live_ra = oid;
    ord_we = 1'b0; ord_wa = oid; ord_wd = '0; ord_ra = oid;
    div_start = 1'b0;
    mul_a = cnt;
    unique case (state)
      S_CLEAR: begin
        act_we  = 32'(clr) < 32'(LEVELS);
        act_wa  = LW'(clr);
        live_we = 32'(clr) < 32'(ORDERS);
        live_wa = OW'(clr);
        if (32'(clr) == 32'(CLR_N - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        live_ra = OW'(in_data.ord_id);
        ord_ra  = OW'(in_data.ord_id);
        if (in_valid) begin
          state_next = S_RANGE;
        end
      end
      S_RANGE: begin
        if (req.mode == MODE_REMOVE && (oid_big || !live_rd)) begin
          state_next = S_REPORT;
        end else if (req.mode[1]) begin
          state_next = S_REPORT;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (below || 64'(diff) >= 64'(lim)) begin
          state_next = S_REPORT;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        act_ra = div_quot[LW-1:0];
        lvl_ra = div_quot[LW-1:0];
        if (div_done) begin
          if (div_rem != 16'd0) begin
            state_next = S_REPORT;
          end else if (req.mode == MODE_INSERT && (oid_big || live_q)) begin
            state_next = S_REPORT;
          end else begin
            state_next = S_LVL;
          end
        end
      end
      S_LVL: begin
        if (req.mode == MODE_INSERT) begin
          lvl_we  = 1'b1;
          lvl_wd  = '{head: act_rd ? lvl_rd.head : OPW'(oid), tail: OPW'(oid), total: ins_tot};
          ord_we  = 1'b1;
          ord_wd  = '{prev: act_rd ? lvl_rd.tail : NONE_O, next: NONE_O,
                      amount: req.order_qty, level: idx};
          live_we = 1'b1;
          live_wd = 1'b1;
          act_we  = !act_rd;
          act_wd  = 1'b1;
          ord_ra  = OW'(lvl_rd.tail);
          state_next = act_rd ? S_LINK : S_REPORT;
        end else if (!act_rd || ordq.level != idx) begin
          state_next = S_REPORT;
        end else begin
          state_next = S_RM;
        end
      end
      S_LINK: begin
        ord_we = 1'b1;
        ord_wa = OW'(lvlq.tail);
        ord_wd = ord_rd;
        ord_wd.next = OPW'(oid);
        state_next = S_REPORT;
      end
      S_RM: begin
        live_we = 1'b1;
        lvl_we  = 1'b1;
        lvl_wd  = '{head: rm_head, tail: rm_tail, total: rm_tot};
        if (ordq.prev != NONE_O) begin
          ord_ra = OW'(ordq.prev);
          state_next = S_RMP;
        end else if (ordq.next != NONE_O) begin
          ord_ra = OW'(ordq.next);
          state_next = S_RMN;
        end else begin
          act_we = 1'b1;
          state_next = S_BID0;
        end
      end
      S_RMP: begin
        ord_we = 1'b1;
        ord_wa = OW'(ordq.prev);
        ord_wd = ord_rd;
        ord_wd.next = ordq.next;
        ord_ra = OW'(ordq.next);
        state_next = (ordq.next != NONE_O) ? S_RMN : S_REPORT;
      end
      S_RMN: begin
        ord_we = 1'b1;
        ord_wa = OW'(ordq.next);
        ord_wd = ord_rd;
        ord_wd.prev = ordq.prev;
        state_next = S_REPORT;
      end
      S_BID0: begin
        if (bb == IW'(idx) && idx != '0) begin
          state_next = S_BRD;
        end else begin
          state_next = S_ASK0;
        end
      end
      S_BRD: begin
        act_ra = scan;
        state_next = S_BCK;
      end
      S_BCK: begin
        state_next = (act_rd || scan == '0) ? S_ASK0 : S_BRD;
      end
      S_ASK0: begin
        if (ba == IW'(idx) && 32'(idx) != 32'(LEVELS - 1)) begin
          state_next = S_ARD;
        end else begin
          state_next = S_REPORT;
        end
      end
      S_ARD: begin
        act_ra = scan;
        state_next = S_ACK;
      end
      S_ACK: begin
        state_next = (act_rd || 32'(scan) == 32'(LEVELS - 1)) ? S_REPORT : S_ARD;
      end
      S_REPORT: begin
        lvl_ra = bb[LW-1:0];
        mul_a  = bb;
        state_next = S_RB;
      end
      S_RB: begin
        lvl_ra = ba[LW-1:0];
        mul_a  = ba;
        state_next = S_RA;
      end
      S_RA: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      bb  <= NONE_L;
      ba  <= NONE_L;
    end else begin
      unique case (state)
        S_CLEAR: clr <= clr + CW'(1);
        S_IDLE: begin
          req      <= in_data;
          status_r <= ST_OK;
          lq       <= '0;
        end
        S_RANGE: begin
          live_q <= live_rd;
          ordq   <= ord_rd;
          lim    <= mul_p;
          below  <= req.price < base_price;
          diff   <= req.price - base_price;
          if (req.mode == MODE_REMOVE && (oid_big || !live_rd)) begin
            status_r <= ST_NOT_FOUND;
          end
        end
        S_CMP: begin
          if (below || 64'(diff) >= 64'(lim)) begin
            status_r <= ST_RANGE;
          end
        end
        S_DIV: begin
          idx <= div_quot[LW-1:0];
          if (div_done) begin
            if (div_rem != 16'd0) begin
              status_r <= ST_MISALIGN;
            end else if (req.mode == MODE_INSERT && oid_big) begin
              status_r <= ST_NOT_FOUND;
            end else if (req.mode == MODE_INSERT && live_q) begin
              status_r <= ST_DUPLICATE;
            end
          end
        end
        S_LVL: begin
          lvlq <= lvl_rd;
          if (req.mode == MODE_INSERT) begin
            lq <= ins_tot;
            if (bb == NONE_L || bb < IW'(idx)) begin
              bb <= IW'(idx);
            end
            if (ba == NONE_L || IW'(idx) < ba) begin
              ba <= IW'(idx);
            end
          end else if (!act_rd || ordq.level != idx) begin
            status_r <= ST_NOT_FOUND;
          end
        end
        S_RM: begin
          lq <= (ordq.prev == NONE_O && ordq.next == NONE_O) ? '0 : rm_tot;
        end
        S_BID0: begin
          if (bb == IW'(idx)) begin
            bb   <= NONE_L;
            scan <= idx - LW'(1);
          end
        end
        S_BCK: begin
          if (act_rd) begin
            bb <= IW'(scan);
          end else begin
            scan <= scan - LW'(1);
          end
        end
        S_ASK0: begin
          if (ba == IW'(idx)) begin
            ba   <= NONE_L;
            scan <= idx + LW'(1);
          end
        end
        S_ACK: begin
          if (act_rd) begin
            ba <= IW'(scan);
          end else begin
            scan <= scan + LW'(1);
          end
        end
        S_REPORT: prod <= mul_p;
        S_RB: begin
          bid_tot <= lvl_rd.total;
          bid_prc <= base_price + 32'(prod);
          prod    <= mul_p;
        end
        S_RA: begin
          ask_tot <= lvl_rd.total;
          ask_prc <= base_price + 32'(prod);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.status    <= status_r;
      out_data.level_qty <= lq;
      out_data.bid_valid <= bb != NONE_L;
      out_data.bid_price <= (bb != NONE_L) ? bid_prc : '0;
      out_data.bid_qty   <= (bb != NONE_L) ? bid_tot : '0;
      out_data.ask_valid <= ba != NONE_L;
      out_data.ask_price <= (ba != NONE_L) ? ask_prc : '0;
      out_data.ask_qty   <= (ba != NONE_L) ? ask_tot : '0;
    end
  end

endmodule

// ===== sv/obpl_checker.sv =====
// Port-level checks for the order book price level map, bound to the top level.
// Depends on obpl_pkg and order_book_price_level_map_unit_defines.svh.
`include "order_book_price_level_map_unit_defines.svh"

module obpl_checker
  import obpl_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `OBPL_ASSERT_ALWAYS(a_busy_after_reset, rst |=> (in_stall && !out_valid), "not busy after reset")
  `OBPL_ASSERT(a_busy_after_take, (in_valid && !in_stall) |=> in_stall, "took two items at once")
  `OBPL_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "stalled result changed")
  `OBPL_ASSERT(a_status_code, out_valid |-> (out_data.status <= ST_DUPLICATE), "bad status code")
  `OBPL_ASSERT(a_empty_bid, (out_valid && !out_data.bid_valid) |-> (out_data.bid_price == 32'd0 && out_data.bid_qty == '0), "empty bid side not zero")

endmodule

bind order_book_price_level_map_unit obpl_checker u_obpl_checker (.*);

// ===== dv/order_book_price_level_map_unit_test.sv =====
// Self-checking testbench for order_book_price_level_map_unit: directed table then random traffic.
// Depends on obpl_pkg and the block's RTL; results are predicted by an in-bench order book model.
module order_book_price_level_map_unit_test;
  import obpl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLVL = 1024;
  localparam int NORD = 4096;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 2 * NLVL + 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_MIN_PRICE;
  logic [31:0] cfg_data = '0;

  order_book_price_level_map_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct {
    out_t res;
    bit typed;
    logic [2:0] st;
  } book_result_t;

  book_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  logic [31:0] cur_min;
  logic [15:0] cur_tick;
  logic [10:0] cur_count;
  bit lv_active[NLVL];
  int lv_head[NLVL];
  int lv_tail[NLVL];
  logic [47:0] lv_total[NLVL];
  bit od_live[NORD];
  int od_prev[NORD];
  int od_next[NORD];
  logic [31:0] od_amt[NORD];
  int od_lvl[NORD];
  int top_bid;
  int top_ask;
  int live_ids[$];

  function automatic logic [2:0] price_to_level(logic [31:0] price, output int idx);
    longint unsigned tick, cnt, diff;
    tick = (cur_tick == 0) ? 1 : cur_tick;
    cnt = (cur_count > NLVL) ? NLVL : cur_count;
    idx = 0;
    if (price < cur_min) return ST_RANGE;
    diff = price - cur_min;
    if (diff >= cnt * tick) return ST_RANGE;
    if (diff % tick != 0) return ST_MISALIGN;
    idx = int'(diff / tick);
    return ST_OK;
  endfunction

  function automatic logic [31:0] level_price(int idx);
    longint unsigned tick;
    tick = (cur_tick == 0) ? 1 : cur_tick;
    return 32'(cur_min + longint'(idx) * tick);
  endfunction

  function automatic void book_insert(int idx, int oid, logic [31:0] qty);
    if (!lv_active[idx]) begin
      lv_active[idx] = 1;
      lv_head[idx] = oid;
      lv_total[idx] = 0;
      od_prev[oid] = NORD;
    end else begin
      od_prev[oid] = lv_tail[idx];
      od_next[lv_tail[idx]] = oid;
    end
    od_next[oid] = NORD;
    lv_tail[idx] = oid;
    lv_total[idx] = lv_total[idx] + qty;
    od_live[oid] = 1;
    od_amt[oid] = qty;
    od_lvl[oid] = idx;
    live_ids.insert(live_ids.size(), oid);
    if (top_bid >= NLVL || top_bid < idx) top_bid = idx;
    if (top_ask >= NLVL || idx < top_ask) top_ask = idx;
  endfunction

  function automatic void book_remove(int idx, int oid);
    int p, n;
    p = od_prev[oid];
    n = od_next[oid];
    if (p < NORD) od_next[p] = n; else lv_head[idx] = n;
    if (n < NORD) od_prev[n] = p; else lv_tail[idx] = p;
    lv_total[idx] = lv_total[idx] - od_amt[oid];
    od_live[oid] = 0;
    foreach (live_ids[k]) if (live_ids[k] == oid) begin
      live_ids.delete(k);
      break;
    end
    if (lv_head[idx] >= NORD) begin
      lv_active[idx] = 0;
      if (top_bid == idx) begin
        top_bid = NLVL;
        for (int i = idx - 1; i >= 0; i--) if (lv_active[i]) begin
          top_bid = i;
          break;
        end
      end
      if (top_ask == idx) begin
        top_ask = NLVL;
        for (int i = idx + 1; i < NLVL; i++) if (lv_active[i]) begin
          top_ask = i;
          break;
        end
      end
    end
  endfunction

  function automatic out_t book_step(in_t it);
    out_t r;
    int idx, oid;
    r = '0;
    oid = it.ord_id;
    if (it.mode == MODE_INSERT) begin
      r.status = price_to_level(it.price, idx);
      if (r.status == ST_OK) begin
        if (od_live[oid]) r.status = ST_DUPLICATE;
        else begin
          book_insert(idx, oid, it.order_qty);
          r.level_qty = lv_total[idx];
        end
      end
    end else if (it.mode == MODE_REMOVE) begin
      if (!od_live[oid]) r.status = ST_NOT_FOUND;
      else begin
        r.status = price_to_level(it.price, idx);
        if (r.status == ST_OK) begin
          if (!lv_active[idx] || od_lvl[oid] != idx) r.status = ST_NOT_FOUND;
          else begin
            book_remove(idx, oid);
            r.level_qty = lv_active[idx] ? lv_total[idx] : '0;
          end
        end
      end
    end
    if (top_bid < NLVL) begin
      r.bid_valid = 1'b1;
      r.bid_price = level_price(top_bid);
      r.bid_qty = lv_total[top_bid];
    end
    if (top_ask < NLVL) begin
      r.ask_valid = 1'b1;
      r.ask_price = level_price(top_ask);
      r.ask_qty = lv_total[top_ask];
    end
    return r;
  endfunction

  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (index)
      CFG_MIN_PRICE: cur_min = value;
      CFG_TICK_SIZE: cur_tick = value[15:0];
      default: cur_count = value[10:0];
    endcase
  endtask

  task automatic set_book_config(logic [31:0] mp, logic [15:0] tk, logic [10:0] lc);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_MIN_PRICE, mp);
    write_reg(CFG_TICK_SIZE, {16'd0, tk});
    write_reg(CFG_LEVEL_COUNT, {21'd0, lc});
  endtask

  task automatic send_order(in_t it, bit typed, logic [2:0] st);
    book_result_t e;
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    e.res = book_step(it);
    e.typed = typed;
    e.st = st;
    pending_results.insert(pending_results.size(), e);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(negedge clk) begin
    if (!rst) out_stall = ($urandom_range(0, 99) < recv_idle);
  end

  always @(posedge clk) begin
    book_result_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("order_book_price_level_map_unit regression: fail");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $realtime, out_data);
      end else begin
        e = pending_results.pop_front();
        if (e.typed) check_field("status (table)", e.st, out_data.status);
        check_field("status", e.res.status, out_data.status);
        check_field("level_qty", e.res.level_qty, out_data.level_qty);
        check_field("bid_valid", e.res.bid_valid, out_data.bid_valid);
        check_field("bid_price", e.res.bid_price, out_data.bid_price);
        check_field("bid_qty", e.res.bid_qty, out_data.bid_qty);
        check_field("ask_valid", e.res.ask_valid, out_data.ask_valid);
        check_field("ask_price", e.res.ask_price, out_data.ask_price);
        check_field("ask_qty", e.res.ask_qty, out_data.ask_qty);
      end
    end
  end

  typedef struct {
    bit reconfig;
    logic [31:0] mp;
    logic [15:0] tk;
    logic [10:0] lc;
    in_t it;
    bit typed;
    logic [2:0] st;
  } table_row_t;

  typedef struct {
    logic [31:0] mp;
    logic [15:0] tk;
    logic [10:0] lc;
  } book_cfg_t;

  table_row_t directed[$];
  book_cfg_t rand_cfgs[8];

  function automatic table_row_t row(logic [1:0] m, logic [31:0] p, logic [11:0] id,
                                     logic [31:0] q, bit typed, logic [2:0] st);
    table_row_t r;
    r = '{default: '0};
    r.it = '{mode: m, price: p, ord_id: id, order_qty: q};
    r.typed = typed;
    r.st = st;
    return r;
  endfunction

  function automatic void add_row(table_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  function automatic in_t random_order();
    in_t it;
    int cnt, k, pick;
    longint unsigned tick;
    tick = (cur_tick == 0) ? 1 : cur_tick;
    cnt = (cur_count > NLVL) ? NLVL : cur_count;
    it.order_qty = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
    it.ord_id = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NORD - 1)
                                            : $urandom_range(0, 63);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      it.mode = MODE_INSERT;
      k = (cnt == 0) ? 0 : ($urandom_range(0, 1) ? $urandom_range(0, (cnt < 16 ? cnt : 16) - 1)
                                                 : $urandom_range(0, cnt - 1));
      it.price = 32'(cur_min + longint'(k) * tick);
    end else if (pick < 82 && live_ids.size() != 0) begin
      it.mode = MODE_REMOVE;
      it.ord_id = live_ids[$urandom_range(0, live_ids.size() - 1)];
      it.price = level_price(od_lvl[it.ord_id]);
    end else if (pick < 90) begin
      it.mode = $urandom_range(0, 1) ? MODE_QUERY : MODE_SPARE;
      it.price = $urandom;
    end else begin
      it.mode = $urandom_range(0, 1) ? MODE_INSERT : MODE_REMOVE;
      it.price = $urandom;
      it.ord_id = $urandom_range(0, NORD - 1);
    end
    return it;
  endfunction

  initial begin
    table_row_t r;
    cur_min = 0;
    cur_tick = 1;
    cur_count = 11'd1024;
    top_bid = NLVL;
    top_ask = NLVL;
    foreach (lv_active[i]) lv_active[i] = 0;
    foreach (od_live[i]) od_live[i] = 0;

    r = row(MODE_QUERY, 32'd0, 12'd0, 32'd0, 1, ST_OK);
    r.reconfig = 1; r.mp = 0; r.tk = 1; r.lc = 11'd1024;
    add_row(r);
    add_row(row(MODE_INSERT, 32'd0, 12'd0, 32'hFFFF_FFFF, 1, ST_OK));
    add_row(row(MODE_INSERT, 32'd1023, 12'hFFF, 32'd0, 1, ST_OK));
    add_row(row(MODE_INSERT, 32'd1023, 12'd5, 32'hFFFF_FFFF, 1, ST_OK));
    add_row(row(MODE_INSERT, 32'd1024, 12'd1, 32'd5, 1, ST_RANGE));
    add_row(row(MODE_INSERT, 32'hFFFF_FFFF, 12'd1, 32'd5, 1, ST_RANGE));
    add_row(row(MODE_INSERT, 32'd5, 12'd0, 32'd9, 1, ST_DUPLICATE));
    add_row(row(MODE_REMOVE, 32'd0, 12'd7, 32'd0, 1, ST_NOT_FOUND));
    add_row(row(MODE_REMOVE, 32'd5, 12'd0, 32'd0, 1, ST_NOT_FOUND));
    add_row(row(MODE_REMOVE, 32'd2000, 12'd0, 32'd0, 1, ST_RANGE));
    add_row(row(MODE_SPARE, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 1, ST_OK));
    add_row(row(MODE_REMOVE, 32'd1023, 12'hFFF, 32'd0, 1, ST_OK));
    add_row(row(MODE_REMOVE, 32'd0, 12'd0, 32'd0, 1, ST_OK));
    add_row(row(MODE_REMOVE, 32'd1023, 12'd5, 32'd0, 1, ST_OK));
    r = row(MODE_INSERT, 32'd101, 12'd2, 32'd3, 1, ST_MISALIGN);
    r.reconfig = 1; r.mp = 32'd100; r.tk = 16'd3; r.lc = 11'd5;
    add_row(r);
    add_row(row(MODE_INSERT, 32'd99, 12'd2, 32'd3, 1, ST_RANGE));
    add_row(row(MODE_INSERT, 32'd115, 12'd2, 32'd3, 1, ST_RANGE));
    add_row(row(MODE_INSERT, 32'd112, 12'd2, 32'd3, 0, ST_OK));
    add_row(row(MODE_INSERT, 32'd100, 12'd3, 32'd4, 0, ST_OK));
    add_row(row(MODE_INSERT, 32'd100, 12'd4, 32'd6, 0, ST_OK));
    add_row(row(MODE_REMOVE, 32'd100, 12'd3, 32'd0, 0, ST_OK));
    add_row(row(MODE_REMOVE, 32'd100, 12'd2, 32'd0, 1, ST_NOT_FOUND));
    add_row(row(MODE_REMOVE, 32'd112, 12'd2, 32'd0, 0, ST_OK));
    add_row(row(MODE_REMOVE, 32'd100, 12'd4, 32'd0, 0, ST_OK));

    rand_cfgs[0] = '{32'd0, 16'd1, 11'd1024};
    rand_cfgs[1] = '{32'd1000, 16'd5, 11'd64};
    rand_cfgs[2] = '{32'hFFFF_FF00, 16'd0, 11'd2047};
    rand_cfgs[3] = '{32'd7, 16'hFFFF, 11'd3};
    rand_cfgs[4] = '{32'hFFFF_FFFF, 16'd1, 11'd1};
    rand_cfgs[5] = '{32'd50, 16'd1, 11'd0};
    rand_cfgs[6] = '{32'd0, 16'd2, 11'd1};
    rand_cfgs[7] = '{32'd12345, 16'd7, 11'd1024};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      if (directed[i].reconfig)
        set_book_config(directed[i].mp, directed[i].tk, directed[i].lc);
      send_order(directed[i].it, directed[i].typed, directed[i].st);
    end

    for (int n = 0; n < 450; n++) begin
      if (n % 64 == 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        set_book_config(rand_cfgs[n / 64].mp, rand_cfgs[n / 64].tk, rand_cfgs[n / 64].lc);
      end
      if (n < 150) begin
        send_idle = 38; recv_idle = 81;
      end else if (n < 300) begin
        send_idle = 81; recv_idle = 38;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      send_order(random_order(), 0, ST_OK);
    end
    @(negedge clk);
    in_valid = 1'b0;
    send_idle = 0;
    recv_idle = 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("order_book_price_level_map_unit regression: pass");
    end else begin
      $display("order_book_price_level_map_unit regression: fail");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/obpl_pkg.sv
sv/obpl_ram.sv
sv/obpl_div.sv
sv/order_book_price_level_map_unit.sv
sv/obpl_checker.sv
dv/order_book_price_level_map_unit_test.sv
